>>> hdl/load_cell_serial_reader_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the load cell serial reader
// Shared concurrent assertion forms, one property per use.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_SERIAL_READER_CORE_DEFINES_SVH
`define LOAD_CELL_SERIAL_READER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LCSR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LCSR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lcsr_pkg.sv
// ----------------------------------------------------------------------------
// lcsr_pkg
// Types and constants shared by the load cell serial reader modules.
// ----------------------------------------------------------------------------
package lcsr_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int RAW_W        = SAMPLE_BITS;
   localparam int DIFF_W       = RAW_W + 1;
   localparam int DIV_W        = 16;
   localparam int WEIGHT_W     = 8;
   localparam int BITS_W       = 5;
   localparam int DIV_STEPS    = DIFF_W;
   localparam int DCNT_W       = 5;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 40;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = RAW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_DIVISOR = 1'b1;

   localparam logic [RAW_W-1:0] ZERO_OFFSET_RESET   = 24'd8000000;
   localparam logic [DIV_W-1:0] SCALE_DIVISOR_RESET = 16'd1000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX       = 8'd255;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BIT_HIGH,
      PH_BIT_LOW,
      PH_EXTRA_HIGH,
      PH_EXTRA_LOW
   } lcsr_phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ABS,
      BK_DIVIDE,
      BK_FINISH
   } lcsr_back_state_type;

   // one tick classified by the front end
   typedef struct packed {
      logic             clock_level;
      logic             compute;
      logic [RAW_W-1:0] raw;
   } lcsr_job_type;

   // one result beat
   typedef struct packed {
      logic                clock_pin;
      logic [WEIGHT_W-1:0] weight;
      logic                weight_valid;
      logic [RAW_W-1:0]    raw_reading;
   } lcsr_rsp_type;

endpackage

>>> hdl/lcsr_front.sv
// ----------------------------------------------------------------------------
// lcsr_front
// Serial clock sequencer: takes ticks, shifts in bits, classifies each tick.
// ----------------------------------------------------------------------------
`include "load_cell_serial_reader_core_defines.svh"

module lcsr_front
   import lcsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic         in_pin,
   output logic         in_ready,
   input  logic         q_full,
   output logic         push,
   output lcsr_job_type push_job
);

   lcsr_phase_type    phase_ff, phase_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [RAW_W-1:0]  shift_ff, shift_in;
   logic              accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign push     = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bits_ff  <= '0;
         shift_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      phase_in             = phase_ff;
      bits_in              = bits_ff;
      shift_in             = shift_ff;
      push_job.clock_level = 1'b0;
      push_job.compute     = 1'b0;
      push_job.raw         = shift_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (accept && !in_pin) begin
               bits_in  = '0;
               shift_in = '0;
               phase_in = PH_BIT_HIGH;
            end
         end
         PH_BIT_HIGH: begin
            push_job.clock_level = 1'b1;
            if (accept) begin
               shift_in = {shift_ff[RAW_W-2:0], in_pin};
               bits_in  = bits_ff + BITS_W'(1);
               phase_in = PH_BIT_LOW;
            end
         end
         PH_BIT_LOW: begin
            if (accept) begin
               phase_in = (bits_ff >= BITS_W'(SAMPLE_BITS)) ? PH_EXTRA_HIGH : PH_BIT_HIGH;
            end
         end
         PH_EXTRA_HIGH: begin
            push_job.clock_level = 1'b1;
            if (accept) begin
               phase_in = PH_EXTRA_LOW;
            end
         end
         PH_EXTRA_LOW: begin
            push_job.compute = 1'b1;
            if (accept) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   `LCSR_ASSERT_IMP(a_bits_bound, clock, reset, 1'b1, bits_ff <= BITS_W'(SAMPLE_BITS), "bit count past sample width")
   `LCSR_ASSERT_NXT(a_extra_after_bits, clock, reset, accept && phase_ff == PH_BIT_LOW && bits_ff == BITS_W'(SAMPLE_BITS), phase_ff == PH_EXTRA_HIGH, "extra pulse skipped")

endmodule

>>> hdl/lcsr_queue.sv
// ----------------------------------------------------------------------------
// lcsr_queue
// Short register queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
`include "load_cell_serial_reader_core_defines.svh"

module lcsr_queue
   import lcsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lcsr_job_type push_job,
   output logic         full,
   input  logic         pop,
   output lcsr_job_type head,
   output logic         empty
);

   lcsr_job_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      priority if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `LCSR_ASSERT_IMP(a_no_overflow, clock, reset, push, !full, "push into full queue")

endmodule

>>> hdl/lcsr_back.sv
// ----------------------------------------------------------------------------
// lcsr_back
// Executes ticks: passes plain ticks on, runs tare, divide and clamp.
// ----------------------------------------------------------------------------
`include "load_cell_serial_reader_core_defines.svh"

module lcsr_back
   import lcsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [RAW_W-1:0] zero_offset,
   input  logic [DIV_W-1:0] scale_divisor,
   input  logic             q_empty,
   input  lcsr_job_type     q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   output lcsr_rsp_type     rsp,
   input  logic             rsp_ready
);

   lcsr_back_state_type state_ff, state_in;
   logic [DIFF_W-1:0]   num_ff, num_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lcsr_rsp_type        rsp_ff, rsp_in;
   logic [WEIGHT_W-1:0] last_weight_ff, last_weight_in;
   logic [RAW_W-1:0]    last_raw_ff, last_raw_in;

   logic                out_free;
   logic [DIV_W:0]      rem_sh;
   logic                ge;
   logic [DIV_W:0]      rem_sub;
   logic [WEIGHT_W-1:0] clamped;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // one restoring divide step
   assign rem_sh  = {rem_ff, num_ff[DIFF_W-1]};
   assign ge      = (rem_sh >= {1'b0, div_ff});
   assign rem_sub = rem_sh - {1'b0, div_ff};

   always_comb begin
      priority if (neg_ff) begin
         clamped = '0;
      end else if (|num_ff[DIFF_W-1:WEIGHT_W]) begin
         clamped = WEIGHT_MAX;
      end else begin
         clamped = num_ff[WEIGHT_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      dcnt_in        = dcnt_ff;
      neg_in         = neg_ff;
      rsp_in         = rsp_ff;
      last_weight_in = last_weight_ff;
      last_raw_in    = last_raw_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      q_pop          = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               priority if (q_head.compute) begin
                  q_pop       = 1'b1;
                  last_raw_in = q_head.raw;
                  num_in      = {q_head.raw[RAW_W-1], q_head.raw} -
                                {zero_offset[RAW_W-1], zero_offset};
                  div_in      = (scale_divisor == '0) ? DIV_W'(1) : scale_divisor;
                  state_in    = BK_ABS;
               end else if (out_free) begin
                  q_pop               = 1'b1;
                  rsp_valid_in        = 1'b1;
                  rsp_in.clock_pin    = q_head.clock_level;
                  rsp_in.weight       = last_weight_ff;
                  rsp_in.weight_valid = 1'b0;
                  rsp_in.raw_reading  = last_raw_ff;
               end else begin
                  q_pop = 1'b0;
               end
            end
         end
         BK_ABS: begin
            neg_in   = num_ff[DIFF_W-1];
            num_in   = num_ff[DIFF_W-1] ? (~num_ff + DIFF_W'(1)) : num_ff;
            rem_in   = '0;
            dcnt_in  = DCNT_W'(DIV_STEPS);
            state_in = BK_DIVIDE;
         end
         BK_DIVIDE: begin
            num_in  = {num_ff[DIFF_W-2:0], ge};
            rem_in  = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               last_weight_in      = clamped;
               rsp_valid_in        = 1'b1;
               rsp_in.clock_pin    = 1'b0;
               rsp_in.weight       = clamped;
               rsp_in.weight_valid = 1'b1;
               rsp_in.raw_reading  = last_raw_ff;
               state_in            = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_weight_ff <= '0;
         last_raw_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_weight_ff <= last_weight_in;
         last_raw_ff    <= last_raw_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      dcnt_ff <= dcnt_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   `LCSR_ASSERT_IMP(a_valid_clock_low, clock, reset,
      rsp_valid_ff && rsp_ff.weight_valid, !rsp_ff.clock_pin,
      "new weight on a high clock beat")
   `LCSR_ASSERT_NXT(a_divide_runs, clock, reset,
      state_ff == BK_DIVIDE && dcnt_ff != DCNT_W'(1),
      state_ff == BK_DIVIDE && dcnt_ff == $past(dcnt_ff) - DCNT_W'(1),
      "divide step lost")
   `LCSR_ASSERT_IMP(a_no_pop_busy, clock, reset, q_pop, state_ff == BK_IDLE,
      "queue popped while busy")

endmodule

>>> hdl/load_cell_serial_reader_core.sv
// ----------------------------------------------------------------------------
// load_cell_serial_reader_core
// Two-wire readout of a 24-bit bridge converter with tare, scale and clamp.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per half-bit tick; tdata[0] is the data-out pin
//   level of the converter. rsp_* returns exactly one beat per request beat,
//   in order: the serial clock level to drive, the held weight byte, the
//   held raw reading, and tuser[0] set on the beat that ends a conversion.
//   csr_* writes the tare offset (index 0) and scale divisor (index 1);
//   write only while no beat is in flight. A divisor of zero acts as one.
// Path and throughput:
//   An ordinary tick is registered in the queue, then in the rsp register;
//   the block sustains about one tick per cycle while no weight is being
//   computed and rsp does not stall. The tick that closes a conversion runs
//   the 25-step restoring divider; a 2-entry queue lets ticks behind it be accepted.
// Reset:
//   Synchronous, active high. The sequencer returns to waiting for the pin
//   to go low, queue and output empty, weight and raw reading zero, offset
//   8000000 and divisor 1000.
// Stall:
//   A stalled rsp beat holds; the back end stops, the queue fills and
//   req_tready drops until space frees up. No beat is lost.
// ----------------------------------------------------------------------------
module load_cell_serial_reader_core
   import lcsr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: [0] data_pin, [7:1] zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: [0] clock_pin, [8:1] weight, [32:9] raw_reading, [39:33] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: [0] weight_valid
   output logic [0:0]             rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [RAW_W-1:0] zero_offset_ff, zero_offset_in;
   logic [DIV_W-1:0] scale_divisor_ff, scale_divisor_in;

   logic             q_full;
   logic             q_empty;
   logic             push;
   logic             pop;
   lcsr_job_type     push_job;
   lcsr_job_type     head;
   lcsr_rsp_type     rsp;

   // register writes: take the low bits that each register holds
   always_comb begin
      zero_offset_in   = zero_offset_ff;
      scale_divisor_in = scale_divisor_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ZERO_OFFSET:   zero_offset_in   = csr_wdata[RAW_W-1:0];
            CSR_SCALE_DIVISOR: scale_divisor_in = csr_wdata[DIV_W-1:0];
            default: begin
               zero_offset_in   = zero_offset_ff;
               scale_divisor_in = scale_divisor_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff   <= ZERO_OFFSET_RESET;
         scale_divisor_ff <= SCALE_DIVISOR_RESET;
      end else begin
         zero_offset_ff   <= zero_offset_in;
         scale_divisor_ff <= scale_divisor_in;
      end
   end

   // sequence the serial clock and classify each tick
   lcsr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_pin   (req_tdata[0]),
      .in_ready (req_tready),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   // decouple the sequencer from the divide
   lcsr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   // pass ticks on, compute the weight at conversion end
   lcsr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .zero_offset   (zero_offset_ff),
      .scale_divisor (scale_divisor_ff),
      .q_empty       (q_empty),
      .q_head        (head),
      .q_pop         (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp           (rsp),
      .rsp_ready     (rsp_tready)
   );

   assign rsp_tdata = {7'b0, rsp.raw_reading, rsp.weight, rsp.clock_pin};
   assign rsp_tuser = rsp.weight_valid;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the load cell serial reader core. Pin levels go in
// one beat per half-bit tick from a queue of planned ticks, an in-bench
// sequencer predicts every result beat, and each beat that comes back is
// compared field by field with the oldest prediction. Tare and divisor
// change between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import lcsr_pkg::*;

   localparam int IDLE_PCT     = 16;      // chance in a hundred of an idle cycle
   localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
   localparam int DRAIN_GAP    = 40;      // divider latency plus margin
   localparam int FLUSH_TICKS  = 2 * SAMPLE_BITS + 4;
   localparam int RANDOM_TICKS = 1000;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_ZERO_OFFSET;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   load_cell_serial_reader_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted sequencer state and its copy of the registers
   lcsr_phase_type      seq_phase   = PH_IDLE;
   logic [BITS_W-1:0]   bit_count   = '0;
   logic [RAW_W-1:0]    shift_bits  = '0;
   logic                clk_level   = 1'b0;
   logic [WEIGHT_W-1:0] held_weight = '0;
   logic [RAW_W-1:0]    held_raw    = '0;
   logic [RAW_W-1:0]    tare_reg    = ZERO_OFFSET_RESET;
   logic [DIV_W-1:0]    divisor_reg = SCALE_DIVISOR_RESET;

   logic         tick_plan[$];      // ticks built but not yet handed out
   logic         pin_levels[$];     // ticks waiting for the driver
   lcsr_rsp_type readouts_due[$];   // predicted result beats, oldest first

   int idle_pct       = IDLE_PCT;
   int hold_req_count = 0;
   int hold_seen      = 0;
   int stall_left     = 0;
   int mismatches     = 0;
   int cycle_count    = 0;

   // Tare, scale, truncate toward zero, clamp to one byte
   function automatic logic [WEIGHT_W-1:0] tared_weight(logic [RAW_W-1:0] raw);
      int diff;
      int div;
      int quo;
      diff = int'($signed(raw)) - int'($signed(tare_reg));
      // a zero divisor acts as one
      div  = (divisor_reg == '0) ? 1 : int'(divisor_reg);
      quo  = diff / div;
      if (quo < 0)
         quo = 0;
      if (quo > int'(WEIGHT_MAX))
         quo = int'(WEIGHT_MAX);
      return WEIGHT_W'(quo);
   endfunction

   // Advance the sequencer by one half-bit tick and return the beat it emits
   function automatic lcsr_rsp_type reader_tick(logic pin);
      lcsr_rsp_type beat;
      beat.weight_valid = 1'b0;
      case (seq_phase)
         PH_BIT_HIGH: begin
            clk_level  = 1'b1;
            shift_bits = {shift_bits[RAW_W-2:0], pin};
            bit_count  = bit_count + 1'b1;
            seq_phase  = PH_BIT_LOW;
         end
         PH_BIT_LOW: begin
            clk_level = 1'b0;
            if (bit_count >= SAMPLE_BITS)
               seq_phase = PH_EXTRA_HIGH;
            else
               seq_phase = PH_BIT_HIGH;
         end
         PH_EXTRA_HIGH: begin
            clk_level = 1'b1;
            seq_phase = PH_EXTRA_LOW;
         end
         PH_EXTRA_LOW: begin
            clk_level         = 1'b0;
            held_raw          = shift_bits;
            held_weight       = tared_weight(shift_bits);
            beat.weight_valid = 1'b1;
            seq_phase         = PH_IDLE;
         end
         default: begin
            // idle: clock low, a low pin means a reading is ready
            clk_level = 1'b0;
            if (pin == 1'b0) begin
               bit_count  = '0;
               shift_bits = '0;
               seq_phase  = PH_BIT_HIGH;
            end
         end
      endcase
      beat.clock_pin   = clk_level;
      beat.weight      = held_weight;
      beat.raw_reading = held_raw;
      return beat;
   endfunction

   // Driver: offer the next planned tick, record the prediction on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            readouts_due.push_back(reader_tick(req_tdata[0]));
         if (!req_tvalid || req_tready) begin
            if (pin_levels.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_TDATA_W-1){1'b0}}, pin_levels.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Compare one accepted result beat against the oldest prediction
   task automatic check_readout();
      lcsr_rsp_type want;
      if (readouts_due.size() == 0) begin
         if (mismatches < MAX_REPORTS)
            $display("result beat with nothing outstanding: tdata=%010h tuser=%0b",
                     rsp_tdata, rsp_tuser[0]);
         mismatches++;
      end else begin
         want = readouts_due.pop_front();
         if (rsp_tdata[0] !== want.clock_pin || rsp_tdata[8:1] !== want.weight ||
             rsp_tuser[0] !== want.weight_valid ||
             rsp_tdata[32:9] !== want.raw_reading) begin
            if (mismatches < MAX_REPORTS)
               $display({"tick mismatch: want clk=%0b wt=%0d new=%0b raw=%06h,",
                         " got clk=%0b wt=%0d new=%0b raw=%06h"},
                        want.clock_pin, want.weight, want.weight_valid,
                        want.raw_reading, rsp_tdata[0], rsp_tdata[8:1],
                        rsp_tuser[0], rsp_tdata[32:9]);
            mismatches++;
         end
      end
   endtask

   // Monitor: check accepted beats, stall at random, hold off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_readout();
         if (hold_req_count != hold_seen) begin
            // start a long hold-off: the core queue fills and req_tready drops
            hold_seen  <= hold_req_count;
            stall_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // Write one register and update the predicted copy
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_ZERO_OFFSET)
         tare_reg = data;
      else
         divisor_reg = data[DIV_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Write both registers; junk in the divisor's upper bits must be dropped
   task automatic set_config(logic [RAW_W-1:0] tare, logic [DIV_W-1:0] div);
      write_reg(CSR_ZERO_OFFSET, tare);
      write_reg(CSR_SCALE_DIVISOR, {8'($urandom_range(255)), div});
   endtask

   // Plan one well-formed conversion: lead idle ticks, ready, 24 pulses, extra pulse
   task automatic build_conversion(logic [RAW_W-1:0] raw, int lead, bit noisy);
      repeat (lead) tick_plan.push_back(1'b1);
      tick_plan.push_back(1'b0);
      for (int i = RAW_W - 1; i >= 0; i--) begin
         tick_plan.push_back(raw[i]);
         // pin on the low half is ignored; toggle it when noisy
         tick_plan.push_back(noisy ? 1'($urandom_range(1)) : raw[i]);
      end
      tick_plan.push_back(1'($urandom_range(1)));
      tick_plan.push_back(1'($urandom_range(1)));
   endtask

   // Plan a burst of random pins, then enough high ticks to land back in idle
   task automatic build_noise();
      repeat ($urandom_range(60, 3)) tick_plan.push_back(1'($urandom_range(1)));
      repeat (FLUSH_TICKS) tick_plan.push_back(1'b1);
   endtask

   // Hand n planned ticks (all of them for a negative n) to the driver
   task automatic release_ticks(int n);
      @(negedge clock);
      while (tick_plan.size() != 0 && n != 0) begin
         pin_levels.push_back(tick_plan.pop_front());
         n--;
      end
   endtask

   // Wait until every tick is out and answered, then let the divider settle
   task automatic drain();
      do
         @(negedge clock);
      while (pin_levels.size() != 0 || req_tvalid || readouts_due.size() != 0);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   function automatic logic [RAW_W-1:0] pick_raw();
      int div;
      int w;
      div = (divisor_reg == '0) ? 1 : int'(divisor_reg);
      case ($urandom_range(3))
         0: return RAW_W'($urandom);
         1: begin
            case ($urandom_range(3))
               0:       return 24'h800000;
               1:       return 24'h7FFFFF;
               2:       return tare_reg;
               default: return tare_reg - 1'b1;
            endcase
         end
         default: begin
            // aim near the clamp range so weights spread over 0..255 and past it
            w = int'($urandom_range(320)) - 30;
            return RAW_W'(int'(tare_reg) + w * div + int'($urandom_range(div - 1)));
         end
      endcase
   endfunction

   task automatic random_config();
      logic [RAW_W-1:0] tare;
      logic [DIV_W-1:0] div;
      case ($urandom_range(3))
         0:       tare = RAW_W'($urandom);
         1:       tare = 24'h800000;
         2:       tare = 24'h7FFFFF;
         default: tare = RAW_W'($urandom_range(2000000));
      endcase
      case ($urandom_range(4))
         0:       div = DIV_W'($urandom_range(2));
         1:       div = 16'hFFFF;
         default: div = DIV_W'($urandom_range(3000, 1));
      endcase
      set_config(tare, div);
   endtask

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int phase_no;
      int random_ticks;
      phase_no     = 0;
      random_ticks = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset tare and divisor: a plain reading well inside the byte range
      build_conversion(24'd8123456, 3, 1'b0);
      release_ticks(-1);
      drain();

      // No tare, unit divisor: large quotient clamps high, negative clamps low
      set_config(24'h000000, 16'd1);
      build_conversion(24'h7FFFFF, 1, 1'b0);
      build_conversion(24'h800000, 0, 1'b1);
      release_ticks(-1);
      drain();

      // Zero divisor acts as one
      set_config(24'h000000, 16'd0);
      build_conversion(24'd200, 2, 1'b1);
      build_conversion(24'hFFFFFF, 0, 1'b0);
      release_ticks(-1);
      drain();

      // Change registers mid-transfer: the values at compute time must win
      set_config(24'h800000, 16'hFFFF);
      build_conversion(24'h7FFFFF, 1, 1'b0);
      release_ticks(20);
      drain();
      set_config(24'h7FFFFF, 16'd1);
      release_ticks(-1);
      drain();

      // Random phases, each under its own register setting
      while (random_ticks < RANDOM_TICKS) begin
         random_config();
         // keep one phase free of any idling on either side
         idle_pct <= (phase_no == 1) ? 0 : IDLE_PCT;
         repeat ($urandom_range(6, 3)) begin
            if ($urandom_range(4) == 0)
               build_noise();
            else
               build_conversion(pick_raw(), $urandom_range(6), 1'($urandom_range(1)));
         end
         random_ticks += tick_plan.size();
         release_ticks(-1);
         if (phase_no == 2) begin
            // hold off the receiver while the sender keeps offering ticks
            repeat (10) @(posedge clock);
            hold_req_count <= hold_req_count + 1;
         end
         // pause the sender until every predicted beat is back
         drain();
         phase_no++;
      end

      drain();
      if (mismatches == 0 && readouts_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
